/* design/tksi_pkg.sv */
// Package for the top-k sorted insertion table.
// Holds the table sizes, the entry record type, the cell control struct and
// the name clipping function. No dependencies.
`timescale 1ns / 1ps

package tksi_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned NAME_CHARS    = 8;
  localparam int unsigned SECONDS_W     = 31;
  localparam int unsigned NAME_W        = 64;
  localparam int unsigned RANK_W        = 6;

  localparam logic [SECONDS_W-1:0] EMPTY_SECONDS = {SECONDS_W{1'b1}};
  localparam logic [RANK_W-1:0]    LAST_RANK     = RANK_W'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic [SECONDS_W-1:0] seconds;
    logic                 played;
    logic                 won;
    logic [NAME_W-1:0]    name;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{
    seconds: EMPTY_SECONDS,
    played:  1'b0,
    won:     1'b0,
    name:    '0
  };

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

  // Keeps the first NAME_CHARS bytes; everything from the first zero byte on
  // is stored as zero.
  function automatic logic [NAME_W-1:0] clip_name(input logic [NAME_W-1:0] tag);
    logic [NAME_W-1:0] kept;
    logic              alive;
    kept  = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b < NAME_CHARS) begin
        if (tag[8*b +: 8] == 8'h00) begin
          alive = 1'b0;
        end
        if (alive) begin
          kept[8*b +: 8] = tag[8*b +: 8];
        end
      end
    end
    return kept;
  endfunction

endpackage

/* design/tksi_if.sv */
// Request channel interfaces of the top-k sorted insertion table.
// Depends on tksi_pkg for the field widths.
`timescale 1ns / 1ps

interface tksi_in_if;
  logic                             valid;
  logic                             ready;
  logic [tksi_pkg::NAME_W-1:0]      name_tag;
  logic [tksi_pkg::SECONDS_W-1:0]   finish_seconds;
  logic                             won;

  modport source (output valid, output name_tag, output finish_seconds, output won,
                  input ready);
  modport sink   (input valid, input name_tag, input finish_seconds, input won,
                  output ready);
endinterface

interface tksi_out_if;
  logic                             valid;
  logic                             ready;
  logic [tksi_pkg::RANK_W-1:0]      entry_rank;
  logic [tksi_pkg::SECONDS_W-1:0]   entry_seconds;
  logic                             entry_played;
  logic                             entry_won;
  logic [tksi_pkg::NAME_W-1:0]      entry_name;
  logic                             new_entry_here;
  logic                             last;

  modport source (output valid, output entry_rank, output entry_seconds,
                  output entry_played, output entry_won, output entry_name,
                  output new_entry_here, output last, input ready);
  modport sink   (input valid, input entry_rank, input entry_seconds,
                  input entry_played, input entry_won, input entry_name,
                  input new_entry_here, input last, output ready);
endinterface

/* design/tksi_cell.sv */
// One slot of the sorted table chain.
// Depends on tksi_pkg for the entry record and the control struct.
`timescale 1ns / 1ps

module tksi_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tksi_pkg::cell_ctrl_t ctrl_i,
  input  tksi_pkg::entry_t    new_entry_i,
  input  tksi_pkg::entry_t    left_entry_i,
  input  logic                left_better_i,
  input  tksi_pkg::entry_t    right_entry_i,
  input  logic                right_new_i,
  output logic                better_o,
  output tksi_pkg::entry_t    entry_o,
  output logic                new_o
);

  tksi_pkg::entry_t entry_q, entry_d;
  logic             new_q, new_d;

  // The new record has play count 1, so on equal time it wins only over an
  // empty slot.
  assign better_o = (new_entry_i.seconds < entry_q.seconds) ||
                    ((new_entry_i.seconds == entry_q.seconds) && !entry_q.played);

  always_comb begin
    entry_d = entry_q;
    new_d   = new_q;
    if (ctrl_i.insert) begin
      // The better flags form a suffix of the chain: the first better cell
      // takes the new record, the ones after it take their left neighbor.
      if (better_o && left_better_i) begin
        entry_d = left_entry_i;
      end else if (better_o) begin
        entry_d = new_entry_i;
      end
      new_d = better_o && !left_better_i;
    end else if (ctrl_i.rotate) begin
      entry_d = right_entry_i;
      new_d   = right_new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= tksi_pkg::EMPTY_ENTRY;
      new_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      new_q   <= new_d;
    end
  end

  assign entry_o = entry_q;
  assign new_o   = new_q;

endmodule

/* design/top_k_sorted_insert_top.sv */
// Top level of the top-k sorted insertion table: a chain of tksi_cell slots
// and the dump sequencer. Depends on tksi_pkg, tksi_if and tksi_cell.
`timescale 1ns / 1ps

// Usage:
// in_i carries one request: a name tag, a finish time and a won flag. It is
// accepted when valid and ready are both high; ready is high only while no
// table dump is in progress.
// At the accepting edge every slot compares the new record with its own entry
// and the whole chain inserts it, dropping the worst entry.
// Starting the next cycle, out_o emits all TABLE_ENTRIES slots in rank order,
// one per cycle while ready is high, read from slot 0 while the chain rotates
// by one slot toward it on every taken result. After a full dump the table is
// back in place.
// A new request is taken only after the full dump of the last one, since the
// rotating chain has a single output port.
// When the receiver holds ready low, the chain and the rank counter hold, so
// the shown result stays put until taken.
// Reset clears every slot to the empty record (time 2147483647, play count 0)
// and returns the sequencer to idle.
module top_k_sorted_insert_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  tksi_in_if.sink           in_i,
  tksi_out_if.source        out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  localparam int unsigned N = tksi_pkg::TABLE_ENTRIES;

  logic                          state_q, state_d;
  logic [tksi_pkg::RANK_W-1:0]   rank_q, rank_d;

  tksi_pkg::cell_ctrl_t          ctrl;
  tksi_pkg::entry_t              new_entry;
  tksi_pkg::entry_t              entries [N];
  logic [N-1:0]                  better;
  logic [N-1:0]                  new_flags;
  logic                          in_take;
  logic                          out_take;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_take    = in_i.valid && in_i.ready;
  assign out_take   = out_o.valid && out_o.ready;

  assign new_entry.seconds = in_i.finish_seconds;
  assign new_entry.played  = 1'b1;
  assign new_entry.won     = in_i.won;
  assign new_entry.name    = tksi_pkg::clip_name(in_i.name_tag);

  assign ctrl.insert = in_take;
  assign ctrl.rotate = out_take;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int unsigned LEFT  = (i == 0) ? 0 : i - 1;
    localparam int unsigned RIGHT = (i == N - 1) ? 0 : i + 1;

    tksi_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .left_entry_i  (entries[LEFT]),
      .left_better_i ((i == 0) ? 1'b0 : better[LEFT]),
      .right_entry_i (entries[RIGHT]),
      .right_new_i   (new_flags[RIGHT]),
      .better_o      (better[i]),
      .entry_o       (entries[i]),
      .new_o         (new_flags[i])
    );
  end

  always_comb begin
    state_d = state_q;
    rank_d  = rank_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_DUMP;
          rank_d  = '0;
        end
      end
      ST_DUMP: begin
        if (out_take) begin
          rank_d = rank_q + 1'b1;
          if (rank_q == tksi_pkg::LAST_RANK) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
    end
  end

  assign out_o.valid          = (state_q == ST_DUMP);
  assign out_o.entry_rank     = rank_q;
  assign out_o.entry_seconds  = entries[0].seconds;
  assign out_o.entry_played   = entries[0].played;
  assign out_o.entry_won      = entries[0].won;
  assign out_o.entry_name     = entries[0].name;
  assign out_o.new_entry_here = new_flags[0];
  assign out_o.last           = (rank_q == tksi_pkg::LAST_RANK);

`ifndef NO_ASSERTIONS
  // An accepted request always starts a dump in the next cycle.
  a_insert_starts_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (out_o.valid && rank_q == '0))
    else $error("dump did not start after an accepted request");

  // At most one slot carries the mark of the record just inserted.
  a_single_new_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(new_flags) <= 1)
    else $error("more than one slot marked as new");

  // Taking the last result ends the dump and reopens the input.
  a_last_ends_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && out_o.last) |=> (!out_o.valid && in_i.ready))
    else $error("dump did not end after the last result");

  // A stalled result keeps its rank and slot contents.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> ($stable(rank_q) && $stable(entries[0])))
    else $error("table moved while the receiver stalled");
`endif

endmodule
